@@ hw/rtl/dws_pkg.sv @@
// Shared constants, types and codes of the daily window scheduler.
package dws_pkg;

    localparam int MAX_WINDOWS     = 16;
    localparam int MINUTE_W        = 11;
    localparam int OPCODE_W        = 3;
    localparam int REPORT_W        = 5;
    localparam int CFG_COUNT_W     = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int IDX_W           = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W           = $clog2(MAX_WINDOWS + 1);
    localparam int ENTRY_W         = 2 * MINUTE_W;
    localparam int ARITH_W         = 14;
    localparam int SPAN_W          = 13;
    localparam int DIV_W           = 5;
    localparam int BIT_W           = $clog2(SPAN_W);
    localparam int MINUTES_PER_DAY = 1440;
    localparam int RESET_STOP      = 1200;
    localparam int RESET_WINDOW    = 2;
    localparam int RESET_COUNT     = 1;

    typedef logic signed [ARITH_W-1:0] t_arith;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CHECK      = 3'd0,
        OP_ADD        = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_MANUAL_ON  = 3'd3,
        OP_MANUAL_OFF = 3'd4,
        OP_GENERATE   = 3'd5
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_MODE = 3'd0,
        CFG_IRR_START   = 3'd1,
        CFG_IRR_STOP    = 3'd2,
        CFG_IRR_WINDOW  = 3'd3,
        CFG_IRR_COUNT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CMP,
        S_G_BEGIN,
        S_G_END,
        S_G_SPAN,
        S_G_WRAP,
        S_G_DIV,
        S_G_STEP,
        S_G_FIRST,
        S_G_STOP_ADD,
        S_G_STOP_FOLD,
        S_G_NEXT_ADD,
        S_G_NEXT_FOLD
    } t_state;

    typedef struct packed {
        t_arith a;
        t_arith b;
        logic   sub;
    } t_alu_req;

    typedef struct packed {
        logic                output_on;
        logic                turned_on;
        logic                turned_off;
        logic                accepted;
        logic [REPORT_W-1:0] entry_count;
    } t_result;

endpackage

@@ hw/rtl/dws_in_if.sv @@
// Input item channel of the daily window scheduler.
interface dws_in_if;
    import dws_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [MINUTE_W-1:0] current_minute;
    logic [MINUTE_W-1:0] window_start;
    logic [MINUTE_W-1:0] window_stop;

    modport source (
        output valid, opcode, current_minute, window_start, window_stop,
        input  ready
    );

    modport sink (
        input  valid, opcode, current_minute, window_start, window_stop,
        output ready
    );
endinterface

@@ hw/rtl/dws_out_if.sv @@
// Result item channel of the daily window scheduler.
interface dws_out_if;
    import dws_pkg::*;

    logic                valid;
    logic                ready;
    logic                output_on;
    logic                turned_on;
    logic                turned_off;
    logic                accepted;
    logic [REPORT_W-1:0] entry_count;

    modport source (
        output valid, output_on, turned_on, turned_off, accepted, entry_count,
        input  ready
    );

    modport sink (
        input  valid, output_on, turned_on, turned_off, accepted, entry_count,
        output ready
    );
endinterface

@@ hw/rtl/dws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/dws_alu.sv @@
// Shared add/subtract unit used by the arithmetic steps of the generate sequence.
module dws_alu (
    input  dws_pkg::t_alu_req i_req,
    output dws_pkg::t_arith   o_sum
);
    import dws_pkg::*;

    assign o_sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
endmodule

@@ hw/rtl/daily_window_scheduler.sv @@
// Daily window scheduler: a table of up to MAX_WINDOWS minute-of-day windows drives one
// on/off output. Add, clear, manual on and manual off finish in the cycle the item is
// accepted. A check reads the window table one entry at a time through its
// registered-read port and stops at the first hit. A generate runs the whole schedule
// through one shared adder: begin, end and span setup steps, a wrap step if the span
// crosses midnight, a restoring division, repeated subtraction to bring the step below
// a day, a fold of the first start into the day, then stop add and stop fold for each
// window written, with next add and next fold between windows. The result sits in an
// output register, and no new item is taken until the cycle after that result is taken.
module daily_window_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dws_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dws_pkg::MINUTE_W-1:0]     i_cfg_wdata,
    dws_in_if.sink                           i_in,
    dws_out_if.source                        o_out
);
    import dws_pkg::*;

    t_state                  r_state, n_state;
    logic                    r_oval, n_oval;
    t_result                 r_res, n_res;
    logic                    r_level, n_level;
    logic [CNT_W-1:0]        r_count, n_count;

    logic                    r_manual;
    logic [MINUTE_W-1:0]     r_istart, r_istop, r_iwin;
    logic [CFG_COUNT_W-1:0]  r_icount;

    logic [OPCODE_W-1:0]     r_op, n_op;
    logic [MINUTE_W-1:0]     r_cur, n_cur;
    logic                    r_before, n_before;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_lim, n_lim;
    t_arith                  r_begin, n_begin;
    t_arith                  r_end, n_end;
    t_arith                  r_tmp, n_tmp;
    logic [SPAN_W-1:0]       r_span, n_span;
    logic [DIV_W-1:0]        r_rem, n_rem;
    logic [DIV_W-1:0]        r_div, n_div;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [MINUTE_W-1:0]     r_s, n_s;

    t_alu_req                alu_req;
    t_arith                  alu_sum;
    logic                    alu_neg;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [MINUTE_W-1:0]     rd_start, rd_stop;
    logic                    win_hit;
    logic [DIV_W:0]          rem_sh;
    logic                    in_fire;
    logic                    in_ready;
    logic                    finish;
    logic                    acc;
    logic                    before_lvl;
    logic [MINUTE_W-1:0]     fold_min;

    dws_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    dws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign alu_neg  = alu_sum[ARITH_W-1];
    assign rd_start = ram_rdata[ENTRY_W-1:MINUTE_W];
    assign rd_stop  = ram_rdata[MINUTE_W-1:0];
    assign win_hit  = (rd_start > rd_stop) ? ((r_cur >= rd_start) || (r_cur < rd_stop))
                                           : ((r_cur >= rd_start) && (r_cur < rd_stop));
    assign rem_sh   = {r_rem, r_span[SPAN_W-1]};
    assign fold_min = alu_neg ? r_tmp[MINUTE_W-1:0] : alu_sum[MINUTE_W-1:0];

    assign in_ready = (r_state == S_IDLE) && !r_oval;
    assign in_fire  = i_in.valid && in_ready;

    always_comb begin
        n_state    = r_state;
        n_oval     = r_oval;
        n_res      = r_res;
        n_level    = r_level;
        n_count    = r_count;
        n_op       = r_op;
        n_cur      = r_cur;
        n_before   = r_before;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_begin    = r_begin;
        n_end      = r_end;
        n_tmp      = r_tmp;
        n_span     = r_span;
        n_rem      = r_rem;
        n_div      = r_div;
        n_bit      = r_bit;
        n_s        = r_s;
        alu_req    = '{a: r_tmp, b: t_arith'(ARITH_W'(MINUTES_PER_DAY)), sub: 1'b1};
        ram_we     = 1'b0;
        ram_waddr  = r_count[IDX_W-1:0];
        ram_wdata  = {r_s, fold_min};
        finish     = 1'b0;
        acc        = 1'b0;
        before_lvl = (r_state == S_IDLE) ? r_level : r_before;

        if (o_out.valid && o_out.ready) begin
            n_oval = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op     = i_in.opcode;
                    n_cur    = i_in.current_minute;
                    n_before = r_level;
                    n_idx    = '0;
                    n_rem    = '0;
                    n_bit    = '0;
                    n_div    = (r_icount < CFG_COUNT_W'(2)) ? DIV_W'(2)
                                                           : DIV_W'(r_icount - 1'b1);
                    n_lim    = (32'(r_icount) >= MAX_WINDOWS) ? CNT_W'(MAX_WINDOWS)
                                                              : CNT_W'(r_icount);
                    case (t_opcode'(i_in.opcode))
                        OP_CHECK: begin
                            if (!r_manual && (r_count != '0)) begin
                                n_state = S_CHK_RD;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        OP_ADD: begin
                            if (r_count < CNT_W'(MAX_WINDOWS)) begin
                                ram_we    = 1'b1;
                                ram_wdata = {i_in.window_start, i_in.window_stop};
                                n_count   = r_count + 1'b1;
                                acc       = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            finish  = 1'b1;
                        end
                        OP_MANUAL_ON: begin
                            if (r_manual) begin
                                n_level = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        OP_MANUAL_OFF: begin
                            if (r_manual) begin
                                n_level = 1'b0;
                            end
                            finish = 1'b1;
                        end
                        OP_GENERATE: begin
                            n_count = '0;
                            if (r_icount == '0) begin
                                finish = 1'b1;
                            end else begin
                                n_state = S_G_BEGIN;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_CHK_RD: begin
                n_state = S_CHK_CMP;
            end
            S_CHK_CMP: begin
                if (win_hit) begin
                    n_level = 1'b1;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end else if ((r_idx + 1'b1) == r_count) begin
                    n_level = 1'b0;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CHK_RD;
                end
            end
            S_G_BEGIN: begin
                alu_req = '{a: t_arith'(ARITH_W'(r_istart)), b: t_arith'(ARITH_W'(r_iwin)),
                            sub: 1'b1};
                n_begin = alu_sum;
                n_state = S_G_END;
            end
            S_G_END: begin
                alu_req = '{a: t_arith'(ARITH_W'(r_istop)), b: t_arith'(ARITH_W'(r_iwin)),
                            sub: 1'b0};
                n_end   = alu_sum;
                n_state = S_G_SPAN;
            end
            S_G_SPAN: begin
                alu_req = '{a: r_end, b: r_begin, sub: 1'b1};
                if (alu_neg) begin
                    n_tmp   = alu_sum;
                    n_state = S_G_WRAP;
                end else begin
                    n_span  = alu_sum[SPAN_W-1:0];
                    n_state = S_G_DIV;
                end
            end
            S_G_WRAP: begin
                alu_req = '{a: r_tmp, b: t_arith'(ARITH_W'(MINUTES_PER_DAY)), sub: 1'b0};
                n_span  = alu_sum[SPAN_W-1:0];
                n_state = S_G_DIV;
            end
            S_G_DIV: begin
                alu_req = '{a: t_arith'(ARITH_W'(rem_sh)), b: t_arith'(ARITH_W'(r_div)),
                            sub: 1'b1};
                n_rem   = alu_neg ? rem_sh[DIV_W-1:0] : alu_sum[DIV_W-1:0];
                n_span  = {r_span[SPAN_W-2:0], !alu_neg};
                n_bit   = r_bit + 1'b1;
                if (r_bit == BIT_W'(SPAN_W - 1)) begin
                    n_state = S_G_STEP;
                end
            end
            S_G_STEP: begin
                alu_req = '{a: t_arith'(ARITH_W'(r_span)),
                            b: t_arith'(ARITH_W'(MINUTES_PER_DAY)), sub: 1'b1};
                if (alu_neg) begin
                    n_state = S_G_FIRST;
                end else begin
                    n_span = alu_sum[SPAN_W-1:0];
                end
            end
            S_G_FIRST: begin
                alu_req = '{a: r_begin, b: t_arith'(ARITH_W'(MINUTES_PER_DAY)), sub: 1'b0};
                n_s     = r_begin[ARITH_W-1] ? alu_sum[MINUTE_W-1:0] : r_begin[MINUTE_W-1:0];
                n_state = S_G_STOP_ADD;
            end
            S_G_STOP_ADD: begin
                alu_req = '{a: t_arith'(ARITH_W'(r_s)), b: t_arith'(ARITH_W'(r_iwin)),
                            sub: 1'b0};
                n_tmp   = alu_sum;
                n_state = S_G_STOP_FOLD;
            end
            S_G_STOP_FOLD: begin
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                if ((r_count + 1'b1) == r_lim) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_G_NEXT_ADD;
                end
            end
            S_G_NEXT_ADD: begin
                alu_req = '{a: t_arith'(ARITH_W'(r_s)), b: t_arith'(ARITH_W'(r_span)),
                            sub: 1'b0};
                n_tmp   = alu_sum;
                n_state = S_G_NEXT_FOLD;
            end
            S_G_NEXT_FOLD: begin
                n_s     = fold_min;
                n_state = S_G_STOP_ADD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_oval = 1'b1;
            n_res  = '{output_on:   n_level,
                       turned_on:   !before_lvl && n_level,
                       turned_off:  before_lvl && !n_level,
                       accepted:    acc,
                       entry_count: REPORT_W'(n_count)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_level <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual <= 1'b0;
            r_istart <= '0;
            r_istop  <= MINUTE_W'(RESET_STOP);
            r_iwin   <= MINUTE_W'(RESET_WINDOW);
            r_icount <= CFG_COUNT_W'(RESET_COUNT);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MANUAL_MODE: r_manual <= i_cfg_wdata[0];
                CFG_IRR_START:   r_istart <= i_cfg_wdata;
                CFG_IRR_STOP:    r_istop  <= i_cfg_wdata;
                CFG_IRR_WINDOW:  r_iwin   <= i_cfg_wdata;
                CFG_IRR_COUNT:   r_icount <= i_cfg_wdata[CFG_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_op     <= n_op;
        r_cur    <= n_cur;
        r_before <= n_before;
        r_idx    <= n_idx;
        r_lim    <= n_lim;
        r_begin  <= n_begin;
        r_end    <= n_end;
        r_tmp    <= n_tmp;
        r_span   <= n_span;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_bit    <= n_bit;
        r_s      <= n_s;
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_oval;
    assign o_out.output_on   = r_res.output_on;
    assign o_out.turned_on   = r_res.turned_on;
    assign o_out.turned_off  = r_res.turned_off;
    assign o_out.accepted    = r_res.accepted;
    assign o_out.entry_count = r_res.entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOWS))
        else $error("window count above table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready while an item is in progress");

    a_single_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.turned_on && o_out.turned_off))
        else $error("both output edges reported");

    a_level_moves_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_level != $past(r_level))) |-> (r_oval && !$past(r_oval)))
        else $error("output level changed without a new result");

    a_accept_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> (r_op == OP_ADD))
        else $error("accepted flag on an item that is not an add");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench of the daily window scheduler: directed and random items checked by a scoreboard.
module tb;
    import dws_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RESET_CYCLES    = 8;
    localparam int NUM_PHASES      = 13;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASE_SETTLE    = 4;
    localparam int FINAL_SETTLE    = 120;
    localparam int CFG_IDX_LAST    = 2 ** CFG_IDX_W - 1;
    localparam int MINUTE_LAST     = MINUTES_PER_DAY - 1;
    localparam int MINUTE_ALL_ONES = 2 ** MINUTE_W - 1;

    localparam logic [OPCODE_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_HI = 3'd7;

    class window_scoreboard;
        logic [MINUTE_W-1:0] start_min[MAX_WINDOWS];
        logic [MINUTE_W-1:0] stop_min[MAX_WINDOWS];
        int       held;
        bit       level;
        bit       manual;
        int       irr_start;
        int       irr_stop;
        int       irr_window;
        int       irr_count;
        t_result  expected_q[$];
        int       errors;
        int       compared;
        int       refused;

        function new();
            held       = 0;
            level      = 1'b0;
            manual     = 1'b0;
            irr_start  = 0;
            irr_stop   = RESET_STOP;
            irr_window = RESET_WINDOW;
            irr_count  = RESET_COUNT;
            errors     = 0;
            compared   = 0;
            refused    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MINUTE_W-1:0] val);
            case (idx)
                CFG_MANUAL_MODE: manual = val[0];
                CFG_IRR_START:   irr_start = int'(val);
                CFG_IRR_STOP:    irr_stop = int'(val);
                CFG_IRR_WINDOW:  irr_window = int'(val);
                CFG_IRR_COUNT:   irr_count = int'(val[CFG_COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        function bit append_window(logic [MINUTE_W-1:0] s, logic [MINUTE_W-1:0] e);
            if (held >= MAX_WINDOWS) return 1'b0;
            start_min[held] = s;
            stop_min[held]  = e;
            held++;
            return 1'b1;
        endfunction

        function int fold_day(int x);
            int r;
            r = x % MINUTES_PER_DAY;
            if (r < 0) r += MINUTES_PER_DAY;
            return r;
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [MINUTE_W-1:0] cur,
                                logic [MINUTE_W-1:0] ws, logic [MINUTE_W-1:0] we);
            t_result r;
            bit      was_on;
            bit      hit;
            int      lo_edge;
            int      hi_edge;
            int      span;
            int      step;
            int      s;
            was_on     = level;
            r.accepted = 1'b0;
            case (op)
                OP_CHECK: begin
                    if (!manual && held > 0) begin
                        hit = 1'b0;
                        for (int i = 0; i < held; i++) begin
                            if (start_min[i] > stop_min[i])
                                hit |= (cur >= start_min[i]) || (cur < stop_min[i]);
                            else
                                hit |= (cur >= start_min[i]) && (cur < stop_min[i]);
                        end
                        level = hit;
                    end
                end
                OP_ADD: begin
                    r.accepted = append_window(ws, we);
                    if (!r.accepted) refused++;
                end
                OP_CLEAR: held = 0;
                OP_MANUAL_ON: if (manual) level = 1'b1;
                OP_MANUAL_OFF: if (manual) level = 1'b0;
                OP_GENERATE: begin
                    // The span may start before midnight; starts and stops fold into one day.
                    lo_edge = irr_start - irr_window;
                    hi_edge = irr_stop + irr_window;
                    span = (lo_edge > hi_edge) ? MINUTES_PER_DAY - lo_edge + hi_edge
                                               : hi_edge - lo_edge;
                    step = span / ((irr_count < 2) ? 2 : irr_count - 1);
                    held = 0;
                    for (int i = 0; i < irr_count; i++) begin
                        s = fold_day(lo_edge + step * i);
                        void'(append_window(MINUTE_W'(s), MINUTE_W'(fold_day(s + irr_window))));
                    end
                end
                default: ;
            endcase
            r.output_on   = level;
            r.turned_on   = !was_on && level;
            r.turned_off  = was_on && !level;
            r.entry_count = REPORT_W'(held);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [REPORT_W-1:0] want,
                                    logic [REPORT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compared++;
            compare_field("output_on", want.output_on, got.output_on);
            compare_field("turned_on", want.turned_on, got.turned_on);
            compare_field("turned_off", want.turned_off, got.turned_off);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MINUTE_W-1:0]  i_cfg_wdata;

    dws_in_if  item_ch ();
    dws_out_if result_ch ();

    daily_window_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (item_ch),
        .o_out       (result_ch)
    );

    window_scoreboard sb = new();
    bit idling = 1'b1;
    int cycles = 0;
    int items_sent = 0;
    int settings = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (item_ch.valid && item_ch.ready) begin
            sb.note_item(item_ch.opcode, item_ch.current_minute, item_ch.window_start,
                         item_ch.window_stop);
            items_sent++;
        end
        if (result_ch.valid && result_ch.ready) begin
            got.output_on   = result_ch.output_on;
            got.turned_on   = result_ch.turned_on;
            got.turned_off  = result_ch.turned_off;
            got.accepted    = result_ch.accepted;
            got.entry_count = result_ch.entry_count;
            sb.check_result(got);
        end
    end

    initial begin
        result_ch.ready <= 1'b0;
        repeat (RESET_CYCLES + 1) @(posedge i_clk);
        forever begin
            if (idling && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_item(logic [OPCODE_W-1:0] op, logic [MINUTE_W-1:0] cur,
                             logic [MINUTE_W-1:0] ws, logic [MINUTE_W-1:0] we);
        if (idling && $urandom_range(0, 2) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.current_minute <= cur;
        item_ch.window_start   <= ws;
        item_ch.window_stop    <= we;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic drain(int settle);
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MINUTE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_schedule(bit manual, int start_m, int stop_m, int window_m, int count);
        write_reg(CFG_MANUAL_MODE, MINUTE_W'(manual));
        write_reg(CFG_IRR_START, MINUTE_W'(start_m));
        write_reg(CFG_IRR_STOP, MINUTE_W'(stop_m));
        write_reg(CFG_IRR_WINDOW, MINUTE_W'(window_m));
        write_reg(CFG_IRR_COUNT, MINUTE_W'(count));
        settings++;
    endtask

    function automatic logic [MINUTE_W-1:0] pick_minute();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MINUTE_W'(MINUTE_LAST);
            default: return MINUTE_W'($urandom_range(0, MINUTE_LAST));
        endcase
    endfunction

    task automatic random_config();
        bit manual;
        int window_m;
        int count;
        manual = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
            0: window_m = 0;
            1: window_m = MINUTE_LAST;
            2: window_m = $urandom_range(0, MINUTE_LAST);
            default: window_m = $urandom_range(1, 60);
        endcase
        case ($urandom_range(0, 5))
            0: count = 0;
            1: count = 1;
            2: count = MAX_WINDOWS;
            default: count = $urandom_range(0, MAX_WINDOWS);
        endcase
        // Bits above each register's width must be dropped.
        write_reg(CFG_MANUAL_MODE, (MINUTE_W'($urandom) << 1) | MINUTE_W'(manual));
        write_reg(CFG_IRR_START, pick_minute());
        write_reg(CFG_IRR_STOP, pick_minute());
        write_reg(CFG_IRR_WINDOW, MINUTE_W'(window_m));
        write_reg(CFG_IRR_COUNT, (MINUTE_W'($urandom) << CFG_COUNT_W) | MINUTE_W'(count));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_IRR_COUNT + 1, CFG_IDX_LAST)),
                      MINUTE_W'($urandom));
        settings++;
    endtask

    task automatic random_item();
        logic [MINUTE_W-1:0] cur;
        logic [MINUTE_W-1:0] ws;
        logic [MINUTE_W-1:0] we;
        int                  pick;
        cur  = pick_minute();
        ws   = pick_minute();
        we   = ($urandom_range(0, 1) == 0)
             ? pick_minute()
             : MINUTE_W'((int'(ws) + $urandom_range(0, 90)) % MINUTES_PER_DAY);
        pick = $urandom_range(0, 99);
        if (pick < 45)      send_item(OP_CHECK, cur, ws, we);
        else if (pick < 75) send_item(OP_ADD, cur, ws, we);
        else if (pick < 80) send_item(OP_CLEAR, cur, ws, we);
        else if (pick < 86) send_item(OP_MANUAL_ON, cur, ws, we);
        else if (pick < 92) send_item(OP_MANUAL_OFF, cur, ws, we);
        else if (pick < 97) send_item(OP_GENERATE, cur, ws, we);
        else send_item($urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO, cur, ws, we);
    endtask

    initial begin
        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= OP_CHECK;
        item_ch.current_minute <= '0;
        item_ch.window_start   <= '0;
        item_ch.window_stop    <= '0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_MANUAL_MODE;
        i_cfg_wdata            <= '0;
        i_rst_n                <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no windows a check must leave the output alone; spare opcodes do nothing.
        send_item(OP_CHECK, 0, 0, 0);
        send_item(OP_RSVD_LO, MINUTE_W'(MINUTE_ALL_ONES), MINUTE_W'(MINUTE_ALL_ONES),
                  MINUTE_W'(MINUTE_ALL_ONES));
        send_item(OP_RSVD_HI, 0, MINUTE_W'(MINUTE_ALL_ONES), 0);
        send_item(OP_MANUAL_ON, 0, 0, 0);
        send_item(OP_ADD, 0, 100, 200);
        send_item(OP_ADD, 0, 1400, 10);
        send_item(OP_ADD, 0, MINUTE_W'(MINUTE_ALL_ONES), 1500);
        send_item(OP_CHECK, 150, 0, 0);
        send_item(OP_CHECK, MINUTE_W'(MINUTE_ALL_ONES), 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_CHECK, 700, 0, 0);
        send_item(OP_ADD, 0, 100, 200);
        send_item(OP_CHECK, 1024, 0, 0);
        send_item(OP_MANUAL_OFF, 0, 0, 0);
        send_item(OP_GENERATE, 0, 0, 0);
        send_item(OP_CHECK, MINUTE_W'(MINUTE_LAST), 0, 0);
        drain(PHASE_SETTLE);

        set_schedule(1'b0, 0, MINUTE_LAST, 0, MAX_WINDOWS);
        send_item(OP_GENERATE, 0, 0, 0);
        send_item(OP_ADD, 0, 5, 6);
        send_item(OP_CHECK, 0, 0, 0);
        drain(PHASE_SETTLE);

        write_reg(CFG_MANUAL_MODE, 1);
        write_reg(CFG_IDX_W'(CFG_IDX_LAST), MINUTE_W'(MINUTE_ALL_ONES));
        send_item(OP_CHECK, 500, 0, 0);
        send_item(OP_MANUAL_ON, 0, 0, 0);
        send_item(OP_MANUAL_ON, 0, 0, 0);
        send_item(OP_MANUAL_OFF, 0, 0, 0);
        send_item(OP_MANUAL_OFF, 0, 0, 0);
        send_item(OP_MANUAL_ON, 0, 0, 0);
        drain(PHASE_SETTLE);

        set_schedule(1'b0, MINUTE_LAST, 0, MINUTE_LAST, 0);
        send_item(OP_GENERATE, 0, 0, 0);
        send_item(OP_CHECK, 0, 0, 0);
        drain(PHASE_SETTLE);
        set_schedule(1'b0, MINUTE_LAST, 0, 0, 2);
        send_item(OP_GENERATE, 0, 0, 0);
        send_item(OP_CHECK, MINUTE_W'(MINUTE_LAST), 0, 0);
        drain(PHASE_SETTLE);

        for (int p = 0; p < NUM_PHASES; p++) begin
            idling = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            random_config();
            repeat (ITEMS_PER_PHASE) random_item();
            drain(PHASE_SETTLE);
        end

        drain(FINAL_SETTLE);
        $display("tb: %0d items under %0d register settings, %0d results compared",
                 items_sent, settings, sb.compared);
        $display("tb: %0d adds were refused on a full table", sb.refused);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/dws_pkg.sv
hw/rtl/dws_in_if.sv
hw/rtl/dws_out_if.sv
hw/rtl/dws_ram.sv
hw/rtl/dws_alu.sv
hw/rtl/daily_window_scheduler.sv
dv/tb.sv
